[rtl/chg_pkg.sv]
// shared types and constants for the convex hull graham scan unit
// no dependencies; imported by every module of the block
package chg_pkg;

	localparam int MAX_POINTS = 64;
	localparam int COORD_WIDTH = 16;
	localparam int IDX_W = $clog2(MAX_POINTS);
	localparam int CNT_W = $clog2(MAX_POINTS + 1);
	localparam int DW = COORD_WIDTH + 1;
	localparam int PW = 2 * DW;

	typedef struct packed {
		logic signed [15:0] point_x;
		logic signed [15:0] point_y;
		logic               last_point;
	} point_req_t;

	typedef struct packed {
		logic signed [15:0] hull_x;
		logic signed [15:0] hull_y;
		logic               last_vertex;
		logic               overflow;
	} hull_res_t;

	typedef struct packed {
		logic signed [COORD_WIDTH-1:0] x;
		logic signed [COORD_WIDTH-1:0] y;
	} pt_t;

	typedef logic signed [DW-1:0] delta_t;

	typedef struct packed {
		logic   start;
		delta_t ax;
		delta_t ay;
		delta_t bx;
		delta_t by;
	} cu_ctrl_t;

	typedef struct packed {
		logic done;
		logic left;
		logic ahead;
	} cu_res_t;

	typedef enum logic [1:0] {
		CU_IDLE,
		CU_MUL1,
		CU_MUL2,
		CU_CMP
	} cu_state_t;

	typedef enum logic [4:0] {
		S_IDLE,
		S_PV_RD,
		S_PV_CMP,
		S_SW_RD,
		S_SW_WR,
		S_SW_WR0,
		S_SO_RDT,
		S_SO_LDT,
		S_SO_CHK,
		S_SO_LDC,
		S_SO_WAIT,
		S_SC_RD0,
		S_SC_RD1,
		S_SC_LD1,
		S_SC_RDT,
		S_SC_LDT,
		S_SC_CHK,
		S_SC_WAIT,
		S_SC_LDS,
		S_OUT_RD,
		S_OUT_EM
	} seq_state_t;

	// difference of two coordinates, one bit wider
	function automatic delta_t sub_pt(input logic signed [COORD_WIDTH-1:0] a,
			input logic signed [COORD_WIDTH-1:0] b);
		sub_pt = DW'(a) - DW'(b);
	endfunction

endpackage

[rtl/chg_cross_unit.sv]
// shared cross product and angle order unit, one multiplier used twice
// depends on chg_pkg
module chg_cross_unit import chg_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  cu_ctrl_t ctrl,
	output cu_res_t  res
);

	cu_state_t state_q, state_d;
	delta_t ax_q, ay_q, bx_q, by_q;
	logic signed [PW-1:0] p1_q, p2_q, prod;
	logic signed [PW:0] diff;
	logic [DW-1:0] max_a, may_a, mbx_a, mby_a;
	logic [DW:0] sum_a, sum_b;
	logic za, zb;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			CU_IDLE: if (ctrl.start) state_d = CU_MUL1;
			CU_MUL1: state_d = CU_MUL2;
			CU_MUL2: state_d = CU_CMP;
			CU_CMP:  state_d = CU_IDLE;
			default: state_d = CU_IDLE;
		endcase
	end

	// shared multiplier
	always_comb begin
		if (state_q == CU_MUL1) prod = ax_q * by_q;
		else prod = ay_q * bx_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= CU_IDLE;
		else state_q <= state_d;
	end

	always_ff @(posedge clk) begin
		if (state_q == CU_IDLE && ctrl.start) begin
			ax_q <= ctrl.ax;
			ay_q <= ctrl.ay;
			bx_q <= ctrl.bx;
			by_q <= ctrl.by;
		end
		if (state_q == CU_MUL1) p1_q <= prod;
		if (state_q == CU_MUL2) p2_q <= prod;
	end

	// sign of cross product and nearness tie break
	always_comb begin
		diff = (PW+1)'(p1_q) - (PW+1)'(p2_q);
		max_a = ax_q[DW-1] ? DW'(-ax_q) : DW'(ax_q);
		may_a = ay_q[DW-1] ? DW'(-ay_q) : DW'(ay_q);
		mbx_a = bx_q[DW-1] ? DW'(-bx_q) : DW'(bx_q);
		mby_a = by_q[DW-1] ? DW'(-by_q) : DW'(by_q);
		sum_a = (DW+1)'(max_a) + (DW+1)'(may_a);
		sum_b = (DW+1)'(mbx_a) + (DW+1)'(mby_a);
		za = (ax_q == '0) && (ay_q == '0);
		zb = (bx_q == '0) && (by_q == '0);
	end

	// outputs
	always_comb begin
		res.done = (state_q == CU_CMP);
		res.left = !diff[PW] && (diff != '0);
		if (za) res.ahead = !zb;
		else if (zb) res.ahead = 1'b0;
		else if (diff != '0) res.ahead = !diff[PW];
		else res.ahead = sum_a < sum_b;
	end

endmodule

[rtl/convex_hull_graham_scan_unit.sv]
// after the last point: pivot search, swap, insertion sort, then the scan with its pops,
// then the hull vertices are emitted in stack order
// throughput: one point request per cycle while loading; busy through the hull run
// the shared cross unit (two multiplies, one compare) sets the sort and scan step time
// results appear for one cycle on hull_valid; the receiver cannot stall
// reset clears the sequencer, point count and overflow flag; point store is not cleared
module convex_hull_graham_scan_unit import chg_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	input  point_req_t point,
	output logic       busy,
	output hull_res_t  hull,
	output logic       hull_valid
);

	seq_state_t state_q, state_d;
	logic [CNT_W-1:0] count_q, i_q, j_q;
	logic [IDX_W-1:0] k_q, o_q, piv_q;
	logic ovf_q;
	pt_t best_q, pivot_q, t_q, c_q, top_q, sec_q, rd_q, srd_q, in_pt;
	pt_t mem [MAX_POINTS];
	pt_t stk [MAX_POINTS];

	logic accept;
	logic [IDX_W-1:0] rd_addr, wr_addr, srd_addr, swr_addr;
	logic wr_en, swr_en;
	pt_t wr_data, swr_data;
	logic [COORD_WIDTH+15:0] ox, oy;
	logic [COORD_WIDTH+15:0] ix, iy;
	cu_ctrl_t cu_ctrl;
	cu_res_t cu_res;
	logic better, do_pop, do_push, last_i;

	assign accept = start && !busy;
	assign busy = (state_q != S_IDLE);
	assign ix = {{COORD_WIDTH{1'b0}}, point.point_x};
	assign iy = {{COORD_WIDTH{1'b0}}, point.point_y};
	assign in_pt = '{x: ix[COORD_WIDTH-1:0], y: iy[COORD_WIDTH-1:0]};
	assign better = (rd_q.y < best_q.y) || ((rd_q.y == best_q.y) && (rd_q.x > best_q.x));
	assign last_i = (CNT_W'(i_q + 1'b1) >= count_q);

	chg_cross_unit u_cross (
		.clk   (clk),
		.arst_n(arst_n),
		.ctrl  (cu_ctrl),
		.res   (cu_res)
	);

	// cross unit operands
	always_comb begin
		cu_ctrl.start = 1'b0;
		cu_ctrl.ax = sub_pt(top_q.x, sec_q.x);
		cu_ctrl.ay = sub_pt(top_q.y, sec_q.y);
		cu_ctrl.bx = sub_pt(t_q.x, sec_q.x);
		cu_ctrl.by = sub_pt(t_q.y, sec_q.y);
		if (state_q == S_SO_LDC) begin
			cu_ctrl.start = 1'b1;
			cu_ctrl.ax = sub_pt(t_q.x, pivot_q.x);
			cu_ctrl.ay = sub_pt(t_q.y, pivot_q.y);
			cu_ctrl.bx = sub_pt(rd_q.x, pivot_q.x);
			cu_ctrl.by = sub_pt(rd_q.y, pivot_q.y);
		end else if (state_q == S_SC_CHK && k_q != '0) begin
			cu_ctrl.start = 1'b1;
		end
	end

	assign do_pop = (state_q == S_SC_WAIT) && cu_res.done && !cu_res.left;
	assign do_push = ((state_q == S_SC_WAIT) && cu_res.done && cu_res.left) ||
		((state_q == S_SC_CHK) && k_q == '0);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE:   if (accept && point.last_point) state_d = S_PV_RD;
			S_PV_RD:  state_d = S_PV_CMP;
			S_PV_CMP: state_d = last_i ? S_SW_RD : S_PV_RD;
			S_SW_RD:  state_d = S_SW_WR;
			S_SW_WR:  state_d = S_SW_WR0;
			S_SW_WR0: state_d = (count_q > CNT_W'(2)) ? S_SO_RDT : S_SC_RD0;
			S_SO_RDT: state_d = S_SO_LDT;
			S_SO_LDT: state_d = S_SO_CHK;
			S_SO_CHK: begin
				if (j_q > CNT_W'(1)) state_d = S_SO_LDC;
				else state_d = last_i ? S_SC_RD0 : S_SO_RDT;
			end
			S_SO_LDC: state_d = S_SO_WAIT;
			S_SO_WAIT: begin
				if (cu_res.done) begin
					if (cu_res.ahead) state_d = S_SO_CHK;
					else state_d = last_i ? S_SC_RD0 : S_SO_RDT;
				end
			end
			S_SC_RD0: state_d = S_SC_RD1;
			S_SC_RD1: state_d = (count_q == CNT_W'(1)) ? S_OUT_RD : S_SC_LD1;
			S_SC_LD1: state_d = S_SC_RDT;
			S_SC_RDT: state_d = (i_q < count_q) ? S_SC_LDT : S_OUT_RD;
			S_SC_LDT: state_d = S_SC_CHK;
			S_SC_CHK: state_d = (k_q != '0) ? S_SC_WAIT : S_SC_RDT;
			S_SC_WAIT: begin
				if (do_push) state_d = S_SC_RDT;
				else if (do_pop) state_d = (k_q > IDX_W'(1)) ? S_SC_LDS : S_SC_CHK;
			end
			S_SC_LDS: state_d = S_SC_CHK;
			S_OUT_RD: state_d = S_OUT_EM;
			S_OUT_EM: state_d = (o_q == k_q) ? S_IDLE : S_OUT_RD;
			default:  state_d = S_IDLE;
		endcase
	end

	// memory port control
	always_comb begin
		rd_addr = '0;
		wr_en = 1'b0;
		wr_addr = count_q[IDX_W-1:0];
		wr_data = in_pt;
		srd_addr = o_q;
		swr_en = 1'b0;
		swr_addr = '0;
		swr_data = rd_q;
		unique case (state_q)
			S_IDLE: wr_en = accept && (count_q < CNT_W'(MAX_POINTS));
			S_PV_RD, S_SO_RDT: rd_addr = i_q[IDX_W-1:0];
			S_SC_RDT: rd_addr = i_q[IDX_W-1:0];
			S_SW_WR: begin
				wr_en = 1'b1;
				wr_addr = piv_q;
				wr_data = rd_q;
			end
			S_SW_WR0: begin
				wr_en = 1'b1;
				wr_addr = '0;
				wr_data = best_q;
			end
			S_SO_CHK: begin
				rd_addr = IDX_W'(j_q - 1'b1);
				wr_en = (j_q <= CNT_W'(1));
				wr_addr = j_q[IDX_W-1:0];
				wr_data = t_q;
			end
			S_SO_WAIT: begin
				wr_en = cu_res.done;
				wr_addr = j_q[IDX_W-1:0];
				wr_data = cu_res.ahead ? c_q : t_q;
			end
			S_SC_RD1: begin
				rd_addr = IDX_W'(1);
				swr_en = 1'b1;
			end
			S_SC_LD1: begin
				swr_en = 1'b1;
				swr_addr = IDX_W'(1);
			end
			S_SC_CHK, S_SC_WAIT: begin
				swr_en = do_push;
				swr_addr = IDX_W'(k_q + 1'b1);
				swr_data = t_q;
				srd_addr = IDX_W'(k_q - IDX_W'(2));
			end
			default: ;
		endcase
	end

	// point store and stack memories
	always_ff @(posedge clk) begin
		if (wr_en) mem[wr_addr] <= wr_data;
		rd_q <= mem[rd_addr];
		if (swr_en) stk[swr_addr] <= swr_data;
		srd_q <= stk[srd_addr];
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			ovf_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == S_IDLE && accept) begin
				if (count_q < CNT_W'(MAX_POINTS)) count_q <= CNT_W'(count_q + 1'b1);
				else ovf_q <= 1'b1;
			end
			if (state_q == S_OUT_EM && o_q == k_q) begin
				count_q <= '0;
				ovf_q <= 1'b0;
			end
		end
	end

	// working registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: i_q <= '0;
			S_PV_CMP: begin
				if (i_q == '0 || better) begin
					best_q <= rd_q;
					piv_q <= i_q[IDX_W-1:0];
				end
				i_q <= last_i ? CNT_W'(2) : CNT_W'(i_q + 1'b1);
			end
			S_SW_WR0: pivot_q <= best_q;
			S_SO_LDT: begin
				t_q <= rd_q;
				j_q <= i_q;
			end
			S_SO_CHK: if (j_q <= CNT_W'(1)) i_q <= CNT_W'(i_q + 1'b1);
			S_SO_LDC: c_q <= rd_q;
			S_SO_WAIT: begin
				if (cu_res.done) begin
					if (cu_res.ahead) j_q <= CNT_W'(j_q - 1'b1);
					else i_q <= CNT_W'(i_q + 1'b1);
				end
			end
			S_SC_RD1: begin
				sec_q <= rd_q;
				k_q <= '0;
				o_q <= '0;
			end
			S_SC_LD1: begin
				top_q <= rd_q;
				k_q <= IDX_W'(1);
				i_q <= CNT_W'(2);
			end
			S_SC_RDT: o_q <= '0;
			S_SC_LDT: t_q <= rd_q;
			S_SC_CHK, S_SC_WAIT: begin
				if (do_push) begin
					k_q <= IDX_W'(k_q + 1'b1);
					sec_q <= top_q;
					top_q <= t_q;
					i_q <= CNT_W'(i_q + 1'b1);
				end else if (do_pop) begin
					k_q <= IDX_W'(k_q - 1'b1);
					top_q <= sec_q;
				end
			end
			S_SC_LDS: sec_q <= srd_q;
			S_OUT_EM: o_q <= IDX_W'(o_q + 1'b1);
			default: ;
		endcase
	end

	// result port
	assign ox = {16'b0, srd_q.x};
	assign oy = {16'b0, srd_q.y};
	assign hull_valid = (state_q == S_OUT_EM);
	assign hull = '{hull_x: ox[15:0], hull_y: oy[15:0],
		last_vertex: (o_q == k_q), overflow: ovf_q};

	// checks
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(MAX_POINTS)) else $error("point count beyond store");
	a_cu_done_wait: assert property (@(posedge clk) disable iff (!arst_n)
		cu_res.done |-> (state_q == S_SO_WAIT || state_q == S_SC_WAIT))
		else $error("cross unit finished outside a wait state");
	a_last_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(hull_valid && hull.last_vertex) |=> (!busy && count_q == '0))
		else $error("run did not end after final vertex");
	a_scan_order: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SC_CHK) |-> (CNT_W'(k_q) < i_q))
		else $error("stack deeper than points scanned");

endmodule

[verif/testbench.sv]
// testbench for convex_hull_graham_scan_unit: point sets in, hull vertices out, checked
// against an in-bench graham scan predictor; depends on chg_pkg and the unit rtl only
module testbench;
	import chg_pkg::*;

	logic       clk;
	logic       arst_n;
	logic       start;
	point_req_t point;
	logic       busy;
	hull_res_t  hull;
	logic       hull_valid;

	convex_hull_graham_scan_unit u_top (
		.clk(clk), .arst_n(arst_n), .start(start), .point(point),
		.busy(busy), .hull(hull), .hull_valid(hull_valid)
	);

	localparam int WATCHDOG_LIMIT = 200000;

	// predictor state
	logic signed [15:0] set_x [MAX_POINTS];
	logic signed [15:0] set_y [MAX_POINTS];
	int                 set_count;
	bit                 set_dropped;
	hull_res_t          hull_expected [$];

	int errors;
	int requests_sent;
	int vertices_seen;
	int sets_done;
	int idle_cycles;

	// clock
	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// sign of a*b - c*d, exact in 64 bits for 17-bit operands
	function automatic int prod_sign(longint a, longint b, longint c, longint d);
		longint diff;
		diff = a * b - c * d;
		return (diff > 0) ? 1 : ((diff < 0) ? -1 : 0);
	endfunction

	function automatic longint mag(longint a);
		return (a < 0) ? -a : a;
	endfunction

	function automatic bit angle_first(longint ax, longint ay, longint bx, longint by);
		int c;
		if (ax == 0 && ay == 0)
			return !(bx == 0 && by == 0);
		if (bx == 0 && by == 0)
			return 1'b0;
		c = prod_sign(ax, by, ay, bx);
		if (c != 0)
			return c > 0;
		return mag(ax) + mag(ay) < mag(bx) + mag(by);
	endfunction

	// store one point; on the last point compute the hull and queue its vertices
	task automatic predict_hull(point_req_t p);
		longint wx [MAX_POINTS];
		longint wy [MAX_POINTS];
		longint sx [MAX_POINTS];
		longint sy [MAX_POINTS];
		longint px, py, tx, ty;
		int n, piv, i, j, k;
		hull_res_t r;
		if (set_count < MAX_POINTS) begin
			set_x[set_count] = p.point_x;
			set_y[set_count] = p.point_y;
			set_count++;
		end else begin
			set_dropped = 1'b1;
		end
		if (!p.last_point)
			return;
		n = set_count;
		for (i = 0; i < n; i++) begin
			wx[i] = set_x[i];
			wy[i] = set_y[i];
		end
		// pivot: lowest y, then largest x
		piv = 0;
		for (i = 1; i < n; i++)
			if (wy[i] < wy[piv] || (wy[i] == wy[piv] && wx[i] > wx[piv]))
				piv = i;
		tx = wx[0]; ty = wy[0];
		wx[0] = wx[piv]; wy[0] = wy[piv];
		wx[piv] = tx; wy[piv] = ty;
		px = wx[0]; py = wy[0];
		// stable angular sort about the pivot
		for (i = 2; i < n; i++) begin
			tx = wx[i]; ty = wy[i];
			j = i;
			while (j > 1 && angle_first(tx - px, ty - py, wx[j-1] - px, wy[j-1] - py)) begin
				wx[j] = wx[j-1];
				wy[j] = wy[j-1];
				j--;
			end
			wx[j] = tx; wy[j] = ty;
		end
		// scan, popping on right or collinear turns
		sx[0] = wx[0]; sy[0] = wy[0];
		k = 0;
		if (n > 1) begin
			sx[1] = wx[1]; sy[1] = wy[1];
			k = 1;
			for (i = 2; i < n; i++) begin
				while (k > 0 && prod_sign(sx[k] - sx[k-1], wy[i] - sy[k-1],
						sy[k] - sy[k-1], wx[i] - sx[k-1]) <= 0)
					k--;
				k++;
				sx[k] = wx[i];
				sy[k] = wy[i];
			end
		end
		for (i = 0; i <= k; i++) begin
			r.hull_x      = 16'(sx[i]);
			r.hull_y      = 16'(sy[i]);
			r.last_vertex = (i == k);
			r.overflow    = set_dropped;
			hull_expected = {hull_expected, r};
		end
		set_count   = 0;
		set_dropped = 1'b0;
	endtask

	task automatic report_mismatch(string what);
		$display("mismatch at %0t: %s", $realtime, what);
		errors++;
	endtask

	// result checker and watchdog
	always @(posedge clk) begin
		hull_res_t e;
		if (arst_n && hull_valid) begin
			vertices_seen++;
			if (hull_expected.size() == 0) begin
				report_mismatch($sformatf("unexpected vertex (%0d,%0d)",
					hull.hull_x, hull.hull_y));
			end else begin
				e = hull_expected.pop_front();
				if (hull.hull_x !== e.hull_x)
					report_mismatch($sformatf("hull_x %0d want %0d", hull.hull_x, e.hull_x));
				if (hull.hull_y !== e.hull_y)
					report_mismatch($sformatf("hull_y %0d want %0d", hull.hull_y, e.hull_y));
				if (hull.last_vertex !== e.last_vertex)
					report_mismatch($sformatf("last_vertex %0b want %0b",
						hull.last_vertex, e.last_vertex));
				if (hull.overflow !== e.overflow)
					report_mismatch($sformatf("overflow %0b want %0b",
						hull.overflow, e.overflow));
				if (e.last_vertex)
					sets_done++;
			end
		end
		if (arst_n && ((start && !busy) || hull_valid))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("watchdog expired with %0d vertices pending", hull_expected.size());
			$display("*** FAILED ***");
			$finish;
		end
	end

	// sender: idle at random, then hold start until accepted
	bit sender_quiet;

	task automatic send_request(logic signed [15:0] x, logic signed [15:0] y, bit last);
		while (!sender_quiet && $urandom_range(99) < 38) begin
			start <= 1'b0;
			@(negedge clk);
		end
		start <= 1'b1;
		point <= '{point_x: x, point_y: y, last_point: last};
		// busy only moves at the rising edge, so low here means the next edge accepts
		while (busy)
			@(negedge clk);
		@(posedge clk);
		predict_hull(point);
		requests_sent++;
		@(negedge clk);
	endtask

	task automatic wait_drained();
		start <= 1'b0;
		do
			@(negedge clk);
		while (hull_expected.size() != 0);
	endtask

	function automatic logic signed [15:0] rand_coord(int span);
		case ($urandom_range(9))
			0: return 16'sh7fff;
			1: return 16'sh8000;
			2: return 16'($urandom);
			default: return 16'($signed($urandom_range(2 * span)) - span);
		endcase
	endfunction

	// directed rows: x, y, last point
	typedef struct {
		logic signed [15:0] x;
		logic signed [15:0] y;
		bit                 last;
	} stim_row_t;

	stim_row_t directed [] = '{
		// single point: emitted alone
		'{16'sh7fff, 16'sh8000, 1},
		// two points, pivot sent second
		'{16'sh8000, 16'sh7fff, 0}, '{16'sh7fff, 16'sh8000, 1},
		// extreme square with duplicates and a collinear midpoint
		'{16'sh8000, 16'sh8000, 0}, '{16'sh7fff, 16'sh8000, 0},
		'{16'sh7fff, 16'sh7fff, 0}, '{16'sh8000, 16'sh7fff, 0},
		'{16'sh0000, 16'sh8000, 0}, '{16'sh7fff, 16'sh7fff, 0},
		'{16'sh0000, 16'sh0000, 1},
		// all duplicates
		'{16'sh0005, 16'sh0005, 0}, '{16'sh0005, 16'sh0005, 0}, '{16'sh0005, 16'sh0005, 1},
		// collinear line and pivot tie on y
		'{16'sh0000, 16'sh0000, 0}, '{16'sh0002, 16'sh0002, 0}, '{16'sh0001, 16'sh0001, 0},
		'{16'shfffd, 16'sh0000, 0}, '{16'sh0003, 16'sh0000, 1}
	};

	// stimulus
	initial begin
		int n, i, pts_sent;
		errors = 0; requests_sent = 0; vertices_seen = 0; sets_done = 0;
		idle_cycles = 0; set_count = 0; set_dropped = 1'b0;
		sender_quiet = 1'b0;
		start = 1'b0;
		point = '0;
		arst_n = 1'b0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		foreach (directed[r])
			send_request(directed[r].x, directed[r].y, directed[r].last);
		// store overflow: 66 points, the last one dropped too
		for (i = 0; i < MAX_POINTS + 2; i++)
			send_request(rand_coord(1000), rand_coord(1000), i == MAX_POINTS + 1);
		wait_drained();

		// random sets, mostly small; one stretch with no idling
		pts_sent = 0;
		while (pts_sent < 116) begin
			sender_quiet = (pts_sent > 40 && pts_sent < 80);
			n = ($urandom_range(9) == 0) ? $urandom_range(MAX_POINTS, 20) :
				$urandom_range(12, 1);
			for (i = 0; i < n; i++)
				send_request(rand_coord($urandom_range(1) ? 8 : 30000),
					rand_coord($urandom_range(1) ? 8 : 30000), i == n - 1);
			pts_sent += n;
			if ($urandom_range(5) == 0)
				wait_drained();
		end

		wait_drained();
		repeat (200) @(negedge clk);
		$display("sent %0d point requests, checked %0d hull vertices over %0d sets",
			requests_sent, vertices_seen, sets_done);
		if (errors == 0 && hull_expected.size() == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
